@@ hw/rtl/sib_pkg.sv @@
// Snapshot interpolation buffer: shared types, codes and arithmetic helpers.
// Used by snapshot_interpolation_buffer; depends on nothing.
`default_nettype none

package sib_pkg;

  localparam int DEF_SNAPSHOT_SLOTS = 8;
  localparam int DEF_ENTITIES       = 32;
  localparam int TIME_W             = 48;
  localparam int CFG_W              = 4;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    FM_IDLE,
    FM_FILL,
    FM_SKIP
  } fill_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_DEC,
    ST_INS,
    ST_INS_CMP,
    ST_INS_WR,
    ST_SMP_O,
    ST_SMP_N,
    ST_SRCH,
    ST_DIV,
    ST_MSTART,
    ST_MERGE,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [TIME_W-1:0]  time_stamp;
    logic                      has_entity;
    logic [31:0]               entity_id;
    logic signed [31:0]        pos_x;
    logic signed [31:0]        pos_y;
    logic signed [31:0]        pos_z;
    logic signed [15:0]        heading;
    logic                      last_entity;
  } in_t;

  typedef struct packed {
    logic [31:0]        out_id;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [15:0] out_heading;
    logic               entity_valid;
    logic               last_result;
    logic               status;
  } out_t;

  typedef struct packed {
    logic [31:0]        id;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [15:0] h;
  } ent_t;

  // one merge step between the multiply and the final add
  typedef struct packed {
    logic               valid;
    logic               last;
    logic               status;
    logic               ent_valid;
    logic [31:0]        id;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [15:0] a_h;
    logic signed [50:0] p_x;
    logic signed [50:0] p_y;
    logic signed [50:0] p_z;
    logic signed [33:0] p_h;
  } mstage_t;

  function automatic logic signed [31:0] lerp_pos(input logic signed [31:0] a,
                                                  input logic signed [50:0] p);
    logic signed [50:0] r;
    r = (p + 51'sd32768) >>> 16;
    return a + r[31:0];
  endfunction

  function automatic logic signed [15:0] lerp_yaw(input logic signed [15:0] a,
                                                  input logic signed [33:0] p);
    logic signed [33:0] r;
    r = (p + 34'sd32768) >>> 16;
    return a + r[15:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/snapshot_interpolation_buffer.sv @@
// Snapshot interpolation buffer top level: sequencer, slot and entity memories.
// Depends on sib_pkg.
`default_nettype none

// Usage:
//  An item is taken when start is high and busy is low. Push items carry at most one
//  entity each; sample items return one or more results, each shown on
//  result_o for one cycle with result_valid_o high; the last has last_result.
//  The receiver cannot stall, results stream out at one per cycle.
//  Clear and the unused code are done without leaving the idle state. A push
//  shifts each stored entity with a larger id up one place, then writes the
//  new one (ids held in one memory, one read port walking down the slot).
//  A sample scans slots in the time search, runs the divider when the
//  fraction needs it (one quotient bit per cycle), and then merges the
//  entities of the snapshots into results. Each result passes the merge
//  stage register and then the output register before it appears.
//  The register port cfg_we_i/cfg_wdata_i sets the ring capacity and empties
//  the buffer; write it only while idle.
//  Reset empties the buffer and sets the capacity to SNAPSHOT_SLOTS or 8, whichever
//  is smaller; the memories are not cleared and are never used before they are written.
module snapshot_interpolation_buffer #(
  parameter int SNAPSHOT_SLOTS        = sib_pkg::DEF_SNAPSHOT_SLOTS,
  parameter int ENTITIES_PER_SNAPSHOT = sib_pkg::DEF_ENTITIES
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire sib_pkg::in_t               item_i,
  output logic                            result_valid_o,
  output sib_pkg::out_t                   result_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [sib_pkg::CFG_W-1:0]  cfg_wdata_i
);

  localparam int SW     = (SNAPSHOT_SLOTS > 1) ? $clog2(SNAPSHOT_SLOTS) : 1;
  localparam int HW     = $clog2(SNAPSHOT_SLOTS + 1);
  localparam int CW     = $clog2(ENTITIES_PER_SNAPSHOT + 1);
  localparam int DEPTH  = SNAPSHOT_SLOTS * ENTITIES_PER_SNAPSHOT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW     = sib_pkg::TIME_W;
  localparam int SLOT_W = TW + CW;

  function automatic logic [SW-1:0] phys(input logic [SW-1:0] o, input logic [HW-1:0] k,
                                         input logic [HW-1:0] cap);
    logic [HW:0] s;
    s = (HW+1)'(o) + {1'b0, k};
    if (s >= {1'b0, cap}) s = s - {1'b0, cap};
    return SW'(s);
  endfunction

  function automatic logic [SW-1:0] inc(input logic [SW-1:0] x, input logic [HW-1:0] cap);
    logic [HW:0] s;
    s = (HW+1)'(x) + (HW+1)'(1);
    return (s >= {1'b0, cap}) ? '0 : SW'(s);
  endfunction

  function automatic logic [AW-1:0] ent_addr(input logic [SW-1:0] s, input logic [CW-1:0] p);
    return AW'(s) * AW'(ENTITIES_PER_SNAPSHOT) + AW'(p);
  endfunction

  // control state
  sib_pkg::state_e     state_q, state_d;
  sib_pkg::fill_mode_e mode_q, mode_d;
  logic [HW-1:0]       held_q, held_d;
  logic [HW-1:0]       cap_q, cap_d;
  logic [SW-1:0]       oldest_q, oldest_d;
  logic [SW-1:0]       fill_slot_q, fill_slot_d;
  sib_pkg::mstage_t    m_q, m_d;
  logic                out_valid_q;

  // working registers
  sib_pkg::in_t        in_q, in_d;
  logic [TW-1:0]       fill_time_q, fill_time_d;
  logic [CW-1:0]       fill_cnt_q, fill_cnt_d;
  logic [CW-1:0]       pos_q, pos_d;
  logic [SW-1:0]       idx_q, idx_d;
  logic [HW-1:0]       bi_q, bi_d;
  logic [SW-1:0]       sa_slot_q, sa_slot_d;
  logic [TW-1:0]       sa_time_q, sa_time_d;
  logic [CW-1:0]       sa_cnt_q, sa_cnt_d;
  logic [SW-1:0]       sb_slot_q, sb_slot_d;
  logic [CW-1:0]       sb_cnt_q, sb_cnt_d;
  logic [49:0]         rem_q, rem_d;
  logic [48:0]         span_q, span_d;
  logic [15:0]         quo_q, quo_d;
  logic [3:0]          bitcnt_q, bitcnt_d;
  logic [16:0]         t_q, t_d;
  logic [CW-1:0]       i_q, i_d, j_q, j_d;
  sib_pkg::out_t       out_q, out_d;

  // memories
  logic [SLOT_W-1:0]   slot_mem [SNAPSHOT_SLOTS];
  logic [SLOT_W-1:0]   slot_rd_q;
  logic [SW-1:0]       slot_raddr, slot_waddr;
  logic                slot_we;
  logic [SLOT_W-1:0]   slot_wdata;

  sib_pkg::ent_t       ent_mem [DEPTH];
  sib_pkg::ent_t       rd_a_q, rd_b_q;
  logic [AW-1:0]       ra_a, ra_b, ent_waddr;
  logic                ent_we;
  sib_pkg::ent_t       ent_wdata;

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rd_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    rd_a_q <= ent_mem[ra_a];
    rd_b_q <= ent_mem[ra_b];
  end

  logic [SW-1:0]          newest;
  logic signed [TW-1:0]   rd_time, r_time;
  logic [CW-1:0]          rd_cnt;
  logic signed [TW:0]     span_c, num_c;
  logic [49:0]            rem2;
  logic                   ge;
  logic                   a_ok, b_ok, shared, use_b, last_c;
  sib_pkg::ent_t          lo, hi, new_ent;
  logic signed [32:0]     dx, dy, dz;
  logic signed [15:0]     dh;
  logic signed [17:0]     ts;

  assign busy           = (state_q != sib_pkg::ST_IDLE);
  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  assign newest  = phys(oldest_q, held_q - HW'(1), cap_q);
  assign rd_time = $signed(slot_rd_q[SLOT_W-1:CW]);
  assign rd_cnt  = slot_rd_q[CW-1:0];
  assign r_time  = in_q.time_stamp;

  assign new_ent = '{id: in_q.entity_id, x: in_q.pos_x, y: in_q.pos_y, z: in_q.pos_z,
                     h: in_q.heading};

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    held_d      = held_q;
    cap_d       = cap_q;
    oldest_d    = oldest_q;
    fill_slot_d = fill_slot_q;
    in_d        = in_q;
    fill_time_d = fill_time_q;
    fill_cnt_d  = fill_cnt_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    bi_d        = bi_q;
    sa_slot_d   = sa_slot_q;
    sa_time_d   = sa_time_q;
    sa_cnt_d    = sa_cnt_q;
    sb_slot_d   = sb_slot_q;
    sb_cnt_d    = sb_cnt_q;
    rem_d       = rem_q;
    span_d      = span_q;
    quo_d       = quo_q;
    bitcnt_d    = bitcnt_q;
    t_d         = t_q;
    i_d         = i_q;
    j_d         = j_q;
    m_d         = '0;
    slot_raddr  = newest;
    slot_we     = 1'b0;
    slot_waddr  = fill_slot_q;
    slot_wdata  = {fill_time_q, fill_cnt_q};
    ent_we      = 1'b0;
    ent_waddr   = ent_addr(fill_slot_q, pos_q);
    ent_wdata   = new_ent;
    ra_a        = ent_addr(sa_slot_q, i_q);
    ra_b        = ent_addr(sb_slot_q, j_q);
    span_c      = {rd_time[TW-1], rd_time} - {sa_time_q[TW-1], sa_time_q};
    num_c       = {r_time[TW-1], r_time} - {sa_time_q[TW-1], sa_time_q};
    rem2        = {rem_q[48:0], 1'b0};
    ge          = (rem2 >= {1'b0, span_q});
    a_ok        = (i_q < sa_cnt_q);
    b_ok        = (j_q < sb_cnt_q);
    shared      = a_ok && b_ok && (rd_a_q.id == rd_b_q.id);
    use_b       = !shared && (!a_ok || (b_ok && (rd_b_q.id < rd_a_q.id)));
    lo          = use_b ? rd_b_q : rd_a_q;
    hi          = shared ? rd_b_q : lo;
    ts          = $signed({1'b0, t_q});
    dx          = {hi.x[31], hi.x} - {lo.x[31], lo.x};
    dy          = {hi.y[31], hi.y} - {lo.y[31], lo.y};
    dz          = {hi.z[31], hi.z} - {lo.z[31], lo.z};
    dh          = hi.h - lo.h;
    last_c      = 1'b0;

    unique case (state_q)
      sib_pkg::ST_IDLE: begin
        if (start) begin
          in_d = item_i;
          unique case (item_i.operation)
            sib_pkg::OP_PUSH: begin
              if (mode_q == sib_pkg::FM_IDLE) begin
                state_d = sib_pkg::ST_PUSH_DEC;
              end else if (mode_q == sib_pkg::FM_FILL && item_i.has_entity) begin
                state_d = sib_pkg::ST_INS;
              end else if (item_i.last_entity) begin
                mode_d = sib_pkg::FM_IDLE;
              end
            end
            sib_pkg::OP_SAMPLE: begin
              if (held_q == '0) begin
                m_d.valid  = 1'b1;
                m_d.last   = 1'b1;
                m_d.status = 1'b1;
                state_d    = sib_pkg::ST_DRAIN;
              end else begin
                slot_raddr = oldest_q;
                state_d    = sib_pkg::ST_SMP_O;
              end
            end
            sib_pkg::OP_CLEAR: begin
              held_d      = '0;
              oldest_d    = '0;
              mode_d      = sib_pkg::FM_IDLE;
              fill_slot_d = '0;
            end
            default: ;
          endcase
        end
      end

      sib_pkg::ST_PUSH_DEC: begin
        if (held_q != '0 && in_q.time_stamp < rd_time) begin
          mode_d  = in_q.last_entity ? sib_pkg::FM_IDLE : sib_pkg::FM_SKIP;
          state_d = sib_pkg::ST_IDLE;
        end else begin
          if (held_q != '0 && in_q.time_stamp == rd_time) begin
            fill_slot_d = newest;
          end else if (held_q >= cap_q) begin
            fill_slot_d = oldest_q;
            oldest_d    = inc(oldest_q, cap_q);
          end else begin
            fill_slot_d = phys(oldest_q, held_q, cap_q);
            held_d      = held_q + HW'(1);
          end
          fill_time_d = in_q.time_stamp;
          fill_cnt_d  = '0;
          slot_we     = 1'b1;
          slot_waddr  = fill_slot_d;
          slot_wdata  = {in_q.time_stamp, {CW{1'b0}}};
          mode_d      = sib_pkg::FM_FILL;
          if (in_q.has_entity) begin
            state_d = sib_pkg::ST_INS;
          end else begin
            if (in_q.last_entity) mode_d = sib_pkg::FM_IDLE;
            state_d = sib_pkg::ST_IDLE;
          end
        end
      end

      sib_pkg::ST_INS: begin
        pos_d = fill_cnt_q;
        if (fill_cnt_q >= CW'(ENTITIES_PER_SNAPSHOT)) begin
          if (in_q.last_entity) mode_d = sib_pkg::FM_IDLE;
          state_d = sib_pkg::ST_IDLE;
        end else if (fill_cnt_q == '0) begin
          state_d = sib_pkg::ST_INS_WR;
        end else begin
          ra_a    = ent_addr(fill_slot_q, fill_cnt_q - CW'(1));
          state_d = sib_pkg::ST_INS_CMP;
        end
      end

      sib_pkg::ST_INS_CMP: begin
        if (rd_a_q.id > in_q.entity_id) begin
          ent_we    = 1'b1;
          ent_wdata = rd_a_q;
          pos_d     = pos_q - CW'(1);
          if (pos_q > CW'(1)) begin
            ra_a = ent_addr(fill_slot_q, pos_q - CW'(2));
          end else begin
            state_d = sib_pkg::ST_INS_WR;
          end
        end else begin
          state_d = sib_pkg::ST_INS_WR;
        end
      end

      sib_pkg::ST_INS_WR: begin
        ent_we     = 1'b1;
        fill_cnt_d = fill_cnt_q + CW'(1);
        slot_we    = 1'b1;
        slot_wdata = {fill_time_q, fill_cnt_d};
        if (in_q.last_entity) mode_d = sib_pkg::FM_IDLE;
        state_d    = sib_pkg::ST_IDLE;
      end

      sib_pkg::ST_SMP_O: begin
        sa_slot_d = oldest_q;
        sa_time_d = rd_time;
        sa_cnt_d  = rd_cnt;
        t_d       = '0;
        state_d   = sib_pkg::ST_SMP_N;
      end

      sib_pkg::ST_SMP_N: begin
        if (r_time <= $signed(sa_time_q)) begin
          sb_cnt_d = '0;
          state_d  = sib_pkg::ST_MSTART;
        end else if (r_time >= rd_time) begin
          sa_slot_d = newest;
          sa_cnt_d  = rd_cnt;
          sb_cnt_d  = '0;
          state_d   = sib_pkg::ST_MSTART;
        end else begin
          bi_d       = HW'(1);
          idx_d      = inc(oldest_q, cap_q);
          slot_raddr = idx_d;
          state_d    = sib_pkg::ST_SRCH;
        end
      end

      sib_pkg::ST_SRCH: begin
        if (rd_time < r_time && bi_q != held_q - HW'(1)) begin
          sa_slot_d  = idx_q;
          sa_time_d  = rd_time;
          sa_cnt_d   = rd_cnt;
          bi_d       = bi_q + HW'(1);
          idx_d      = inc(idx_q, cap_q);
          slot_raddr = idx_d;
        end else begin
          sb_slot_d = idx_q;
          sb_cnt_d  = rd_cnt;
          if (span_c <= 0 || num_c <= 0) begin
            t_d     = '0;
            state_d = sib_pkg::ST_MSTART;
          end else if (num_c >= span_c) begin
            t_d     = 17'd65536;
            state_d = sib_pkg::ST_MSTART;
          end else begin
            rem_d    = {1'b0, num_c};
            span_d   = span_c;
            quo_d    = '0;
            bitcnt_d = '0;
            state_d  = sib_pkg::ST_DIV;
          end
        end
      end

      sib_pkg::ST_DIV: begin
        rem_d    = ge ? (rem2 - {1'b0, span_q}) : rem2;
        quo_d    = {quo_q[14:0], ge};
        bitcnt_d = bitcnt_q + 4'd1;
        if (bitcnt_q == 4'd15) begin
          t_d     = {1'b0, quo_d};
          state_d = sib_pkg::ST_MSTART;
        end
      end

      sib_pkg::ST_MSTART: begin
        i_d  = '0;
        j_d  = '0;
        ra_a = ent_addr(sa_slot_q, '0);
        ra_b = ent_addr(sb_slot_q, '0);
        if (sa_cnt_q == '0 && sb_cnt_q == '0) begin
          m_d.valid = 1'b1;
          m_d.last  = 1'b1;
          state_d   = sib_pkg::ST_DRAIN;
        end else begin
          state_d = sib_pkg::ST_MERGE;
        end
      end

      sib_pkg::ST_MERGE: begin
        i_d  = (shared || !use_b) ? i_q + CW'(1) : i_q;
        j_d  = (shared || use_b) ? j_q + CW'(1) : j_q;
        ra_a = ent_addr(sa_slot_q, i_d);
        ra_b = ent_addr(sb_slot_q, j_d);
        last_c        = (i_d == sa_cnt_q) && (j_d == sb_cnt_q);
        m_d.valid     = 1'b1;
        m_d.last      = last_c;
        m_d.ent_valid = 1'b1;
        m_d.id        = lo.id;
        m_d.a_x       = lo.x;
        m_d.a_y       = lo.y;
        m_d.a_z       = lo.z;
        m_d.a_h       = lo.h;
        m_d.p_x       = dx * ts;
        m_d.p_y       = dy * ts;
        m_d.p_z       = dz * ts;
        m_d.p_h       = dh * ts;
        if (last_c) state_d = sib_pkg::ST_DRAIN;
      end

      sib_pkg::ST_DRAIN: begin
        if (!m_q.valid) state_d = sib_pkg::ST_IDLE;
      end

      default: state_d = sib_pkg::ST_IDLE;
    endcase

    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        cap_d = HW'(1);
      end else if (int'(cfg_wdata_i) > SNAPSHOT_SLOTS) begin
        cap_d = HW'(SNAPSHOT_SLOTS);
      end else begin
        cap_d = HW'(cfg_wdata_i);
      end
      held_d      = '0;
      oldest_d    = '0;
      mode_d      = sib_pkg::FM_IDLE;
      fill_slot_d = '0;
    end
  end

  always_comb begin
    out_d.out_id       = m_q.id;
    out_d.out_x        = sib_pkg::lerp_pos(m_q.a_x, m_q.p_x);
    out_d.out_y        = sib_pkg::lerp_pos(m_q.a_y, m_q.p_y);
    out_d.out_z        = sib_pkg::lerp_pos(m_q.a_z, m_q.p_z);
    out_d.out_heading  = sib_pkg::lerp_yaw(m_q.a_h, m_q.p_h);
    out_d.entity_valid = m_q.ent_valid;
    out_d.last_result  = m_q.last;
    out_d.status       = m_q.status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sib_pkg::ST_IDLE;
      mode_q      <= sib_pkg::FM_IDLE;
      held_q      <= '0;
      cap_q       <= (SNAPSHOT_SLOTS > 8) ? HW'(8) : HW'(SNAPSHOT_SLOTS);
      oldest_q    <= '0;
      fill_slot_q <= '0;
      m_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      held_q      <= held_d;
      cap_q       <= cap_d;
      oldest_q    <= oldest_d;
      fill_slot_q <= fill_slot_d;
      m_q         <= m_d;
      out_valid_q <= m_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q        <= in_d;
    fill_time_q <= fill_time_d;
    fill_cnt_q  <= fill_cnt_d;
    pos_q       <= pos_d;
    idx_q       <= idx_d;
    bi_q        <= bi_d;
    sa_slot_q   <= sa_slot_d;
    sa_time_q   <= sa_time_d;
    sa_cnt_q    <= sa_cnt_d;
    sb_slot_q   <= sb_slot_d;
    sb_cnt_q    <= sb_cnt_d;
    rem_q       <= rem_d;
    span_q      <= span_d;
    quo_q       <= quo_d;
    bitcnt_q    <= bitcnt_d;
    t_q         <= t_d;
    i_q         <= i_d;
    j_q         <= j_d;
    out_q       <= out_d;
  end

`ifndef SYNTHESIS
  a_held_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= cap_q)
    else $error("held snapshot count exceeds capacity");

  a_fill_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == sib_pkg::FM_FILL |-> HW'(fill_slot_q) < cap_q)
    else $error("fill slot outside ring");

  a_no_stray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.operation != sib_pkg::OP_SAMPLE |=> !result_valid_o)
    else $error("result after a non-sample item");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status |-> result_o.last_result)
    else $error("empty-buffer result not marked last");
`endif

endmodule

`default_nettype wire
